// File: src/mixed_radix_exchange_partner_top_assert.svh
// assertion macros for the exchange partner block
`ifndef MIXED_RADIX_EXCHANGE_PARTNER_TOP_ASSERT_SVH
`define MIXED_RADIX_EXCHANGE_PARTNER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define MREP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");
`define MREP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MREP_ASSERT(lbl, clk, rstn, prop)
`define MREP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: src/mrep_pkg.sv
// shared types, constants and helpers for the exchange partner block
package mrep_pkg;
    localparam int MAX_LEVELS      = 4;
    localparam int RANK_BITS       = 16;
    localparam int RADIX_BITS      = 17;
    localparam int CHUNK_BITS      = 13;
    localparam int OFFSET_BITS     = 28;
    localparam int CELLS_PER_LEVEL = RANK_BITS + 2;
    localparam int NUM_CELLS       = MAX_LEVELS * CELLS_PER_LEVEL;

    localparam logic [2:0] CFG_LEVEL_COUNT = 3'd0;
    localparam logic [2:0] CFG_RADIX_0     = 3'd1;
    localparam logic [2:0] CFG_RADIX_1     = 3'd2;
    localparam logic [2:0] CFG_RADIX_2     = 3'd3;
    localparam logic [2:0] CFG_RADIX_3     = 3'd4;
    localparam logic [2:0] CFG_CHUNK_SIZE  = 3'd5;

    typedef struct packed {
        logic [RANK_BITS-1:0]  me;
        logic [RANK_BITS-1:0]  a;
        logic [RANK_BITS-1:0]  b;
        logic [RADIX_BITS-1:0] ra;
        logic [RADIX_BITS-1:0] rb;
        logic [RANK_BITS-1:0]  res_d;
        logic [RANK_BITS-1:0]  res_s;
        logic [RANK_BITS-1:0]  mult;
    } t_work;

    function automatic logic [RADIX_BITS-1:0] eff_radix(
        input logic [2:0]            lc,
        input logic [2:0]            lvl,
        input logic [RADIX_BITS-1:0] rg
    );
        logic [2:0] used;
        used = (lc > 3'(MAX_LEVELS)) ? 3'(MAX_LEVELS) : lc;
        if (lvl >= used || rg == '0) begin
            return RADIX_BITS'(1);
        end
        return rg;
    endfunction
endpackage

// File: src/mrep_div_cell.sv
// one restoring division step on both running values
module mrep_div_cell import mrep_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [RADIX_BITS-1:0] i_radix,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_work                 i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_work                 o_data
);
    logic                  r_valid;
    t_work                 r_data;
    t_work                 n_data;
    logic [RADIX_BITS:0]   rem_a;
    logic [RADIX_BITS:0]   rem_b;
    logic                  ge_a;
    logic                  ge_b;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        rem_a = {i_data.ra, i_data.a[RANK_BITS-1]};
        rem_b = {i_data.rb, i_data.b[RANK_BITS-1]};
        ge_a  = rem_a >= {1'b0, i_radix};
        ge_b  = rem_b >= {1'b0, i_radix};
        n_data    = i_data;
        n_data.ra = ge_a ? RADIX_BITS'(rem_a - {1'b0, i_radix}) : RADIX_BITS'(rem_a);
        n_data.rb = ge_b ? RADIX_BITS'(rem_b - {1'b0, i_radix}) : RADIX_BITS'(rem_b);
        n_data.a  = {i_data.a[RANK_BITS-2:0], ge_a};
        n_data.b  = {i_data.b[RANK_BITS-2:0], ge_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: src/mrep_digit_cell.sv
// modular sum and difference of the two digits of one level
module mrep_digit_cell import mrep_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [RADIX_BITS-1:0] i_radix,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_work                 i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_work                 o_data
);
    logic                r_valid;
    t_work               r_data;
    t_work               n_data;
    logic [RADIX_BITS:0] sum;
    logic [RADIX_BITS:0] dif;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        sum = {1'b0, i_data.ra} + {1'b0, i_data.rb};
        if (i_data.ra >= i_data.rb) begin
            dif = {1'b0, i_data.ra} - {1'b0, i_data.rb};
        end else begin
            dif = {1'b0, i_data.ra} + {1'b0, i_radix} - {1'b0, i_data.rb};
        end
        n_data    = i_data;
        n_data.ra = (sum >= {1'b0, i_radix}) ? RADIX_BITS'(sum - {1'b0, i_radix})
                                             : RADIX_BITS'(sum);
        n_data.rb = RADIX_BITS'(dif);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: src/mrep_accum_cell.sv
// folds one level's digits into the partner ranks
module mrep_accum_cell import mrep_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [RADIX_BITS-1:0] i_radix,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_work                 i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_work                 o_data
);
    logic                   r_valid;
    t_work                  r_data;
    t_work                  n_data;
    logic [2*RANK_BITS-1:0] prod_d;
    logic [2*RANK_BITS-1:0] prod_s;
    logic [2*RANK_BITS-1:0] prod_m;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        prod_d       = i_data.ra[RANK_BITS-1:0] * i_data.mult;
        prod_s       = i_data.rb[RANK_BITS-1:0] * i_data.mult;
        prod_m       = i_radix[RANK_BITS-1:0] * i_data.mult;
        n_data       = i_data;
        n_data.res_d = i_data.res_d + prod_d[RANK_BITS-1:0];
        n_data.res_s = i_data.res_s + prod_s[RANK_BITS-1:0];
        n_data.mult  = prod_m[RANK_BITS-1:0];
        n_data.ra    = '0;
        n_data.rb    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: src/mrep_out_cell.sv
// buffer offsets, self copy flag and output register
module mrep_out_cell import mrep_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [CHUNK_BITS-1:0]  i_chunk,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_work                  i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [RANK_BITS-1:0]   o_dest,
    output logic [RANK_BITS-1:0]   o_src,
    output logic                   o_self,
    output logic [OFFSET_BITS-1:0] o_send_off,
    output logic [OFFSET_BITS-1:0] o_recv_off
);
    logic                              r_valid;
    logic [RANK_BITS-1:0]              r_dest;
    logic [RANK_BITS-1:0]              r_src;
    logic                              r_self;
    logic [OFFSET_BITS-1:0]            r_send;
    logic [OFFSET_BITS-1:0]            r_recv;
    logic [RANK_BITS+CHUNK_BITS-1:0]   prod_send;
    logic [RANK_BITS+CHUNK_BITS-1:0]   prod_recv;

    assign o_ready   = !r_valid || i_ready;
    assign prod_send = i_data.res_d * i_chunk;
    assign prod_recv = i_data.res_s * i_chunk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_dest <= i_data.res_d;
            r_src  <= i_data.res_s;
            r_self <= i_data.res_d == i_data.me;
            r_send <= prod_send[OFFSET_BITS-1:0];
            r_recv <= prod_recv[OFFSET_BITS-1:0];
        end
    end

    assign o_valid    = r_valid;
    assign o_dest     = r_dest;
    assign o_src      = r_src;
    assign o_self     = r_self;
    assign o_send_off = r_send;
    assign o_recv_off = r_recv;
endmodule

// File: src/mixed_radix_exchange_partner_top.sv
// top level of the mixed-radix exchange partner block
//  channel   dir  fields
//  s (in)    in   tdata[31:0] = my_rank, phase
//  m (out)   out  tdata[95:0] = dest, src, self_copy,
//                               send_offset, recv_offset, zero fill
//  cfg       in   we, idx[2:0], data[16:0]
// one request per cycle sustained while i_m_tready does not stall the output
// path: 16 division cells, a digit cell and an accumulate cell per level, then output
// each cell holds its request until the next one frees, so gaps close up
// synchronous active-low reset clears all valid flags and level count, sets radices and chunk to one
`include "mixed_radix_exchange_partner_top_assert.svh"
module mixed_radix_exchange_partner_top import mrep_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [31:0]           i_s_tdata,   // my_rank, phase
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [95:0]           o_m_tdata,   // dest, src, self_copy,
                                               // send_offset, recv_offset
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [RADIX_BITS-1:0] i_cfg_data
);
    logic [2:0]            r_level_count;
    logic [RADIX_BITS-1:0] r_radix [MAX_LEVELS];
    logic [CHUNK_BITS-1:0] r_chunk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= '0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_radix[i] <= RADIX_BITS'(1);
            end
            r_chunk <= CHUNK_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEVEL_COUNT: r_level_count <= i_cfg_data[2:0];
                CFG_RADIX_0:     r_radix[0]    <= i_cfg_data;
                CFG_RADIX_1:     r_radix[1]    <= i_cfg_data;
                CFG_RADIX_2:     r_radix[2]    <= i_cfg_data;
                CFG_RADIX_3:     r_radix[3]    <= i_cfg_data;
                CFG_CHUNK_SIZE:  r_chunk       <= i_cfg_data[CHUNK_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic  pv [NUM_CELLS+1];
    logic  pr [NUM_CELLS+1];
    t_work pd [NUM_CELLS+1];
    logic [RADIX_BITS-1:0] lvl_radix [MAX_LEVELS];

    always_comb begin
        pd[0]       = '0;
        pd[0].me    = i_s_tdata[15:0];
        pd[0].a     = i_s_tdata[15:0];
        pd[0].b     = i_s_tdata[31:16];
        pd[0].mult  = RANK_BITS'(1);
    end
    assign pv[0]      = i_s_tvalid;
    assign o_s_tready = pr[0];

    for (genvar l = 0; l < MAX_LEVELS; l++) begin : g_lvl
        assign lvl_radix[l] = eff_radix(r_level_count, 3'(l), r_radix[l]);
        for (genvar k = 0; k < RANK_BITS; k++) begin : g_div
            localparam int S = l * CELLS_PER_LEVEL + k;
            mrep_div_cell u_div (
                .i_clk, .i_rst_n, .i_radix(lvl_radix[l]),
                .i_valid(pv[S]), .o_ready(pr[S]), .i_data(pd[S]),
                .o_valid(pv[S+1]), .i_ready(pr[S+1]), .o_data(pd[S+1])
            );
        end
        localparam int SD = l * CELLS_PER_LEVEL + RANK_BITS;
        mrep_digit_cell u_digit (
            .i_clk, .i_rst_n, .i_radix(lvl_radix[l]),
            .i_valid(pv[SD]), .o_ready(pr[SD]), .i_data(pd[SD]),
            .o_valid(pv[SD+1]), .i_ready(pr[SD+1]), .o_data(pd[SD+1])
        );
        mrep_accum_cell u_accum (
            .i_clk, .i_rst_n, .i_radix(lvl_radix[l]),
            .i_valid(pv[SD+1]), .o_ready(pr[SD+1]), .i_data(pd[SD+1]),
            .o_valid(pv[SD+2]), .i_ready(pr[SD+2]), .o_data(pd[SD+2])
        );
    end

    logic [RANK_BITS-1:0]   dest;
    logic [RANK_BITS-1:0]   src;
    logic                   self_copy;
    logic [OFFSET_BITS-1:0] send_off;
    logic [OFFSET_BITS-1:0] recv_off;

    mrep_out_cell u_out (
        .i_clk, .i_rst_n, .i_chunk(r_chunk),
        .i_valid(pv[NUM_CELLS]), .o_ready(pr[NUM_CELLS]), .i_data(pd[NUM_CELLS]),
        .o_valid(o_m_tvalid), .i_ready(i_m_tready),
        .o_dest(dest), .o_src(src), .o_self(self_copy),
        .o_send_off(send_off), .o_recv_off(recv_off)
    );

    assign o_m_tdata = {7'd0, recv_off, send_off, self_copy, src, dest};

    `MREP_ASSERT(a_full_when_blocked, i_clk, i_rst_n, !o_s_tready |-> (o_m_tvalid && !i_m_tready))
    `MREP_ASSERT(a_zero_dest_offset, i_clk, i_rst_n, (o_m_tvalid && dest == '0) |-> send_off == '0)
    `MREP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid)
endmodule
